// File: rtl/apm_pkg.sv
// shared constants, types and functions of the audio peak level meter
package apm_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int SAMPLE_W         = 32;
  localparam int PEAK_W           = 32;
  localparam int FMT_W            = 3;
  localparam int COUNT_W          = 4;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 4;
  localparam int CHAN_NUM_W       = 3;
  localparam int LEVEL_W          = 7;
  localparam int QUOT_W           = 7;
  localparam int PROD_W           = PEAK_W + QUOT_W;
  localparam int MID_DEPTH        = 2;
  localparam int OUT_DEPTH        = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U8  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_U16 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_U32 = 3'd5;

  localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_S16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

  typedef struct packed {
    logic [CHAN_NUM_W-1:0] channel_number;
    logic [LEVEL_W-1:0]    level_percent;
    logic                  last_level;
  } apm_result_t;

  localparam int RESULT_W = $bits(apm_result_t);

  // full scale of a format, zero for unused codes
  function automatic logic [PEAK_W-1:0] full_scale(input logic [FMT_W-1:0] fmt);
    logic [PEAK_W-1:0] fs;
    case (fmt)
      FMT_S8:  fs = 32'd127;
      FMT_S16: fs = 32'd32767;
      FMT_S32: fs = 32'd2147483647;
      FMT_U8:  fs = 32'd255;
      FMT_U16: fs = 32'd65535;
      FMT_U32: fs = 32'hFFFF_FFFF;
      default: fs = '0;
    endcase
    return fs;
  endfunction

endpackage

// File: rtl/apm_fifo.sv
// small first-in first-out queue held in flops
module apm_fifo import apm_pkg::*; #(
  parameter int WIDTH = RESULT_W,
  parameter int DEPTH = OUT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/apm_front.sv
// front end: channel assignment and per-sample magnitude
module apm_front import apm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int POS_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int NCH_W        = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [FMT_W-1:0]    sample_format,
  input  logic [NCH_W-1:0]    n_eff,
  input  logic [SAMPLE_W-1:0] sample_bits,
  input  logic                buffer_end,
  output logic [POS_W-1:0]    ent_ch,
  output logic [PEAK_W-1:0]   ent_mag,
  output logic                ent_last
);

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [NCH_W-1:0]  pos_inc;
  logic [PEAK_W-1:0] fs;
  logic [PEAK_W-1:0] uval;
  logic [PEAK_W:0]   dbl;
  logic [PEAK_W:0]   fs_ext;
  logic [PEAK_W:0]   udiff;
  logic [8:0]        s8_neg;
  logic [16:0]       s16_neg;

  assign fs = full_scale(sample_format);

  // channel position, wrapped when the count shrank
  always_comb begin
    ent_ch   = (NCH_W'(pos) >= n_eff) ? '0 : pos;
    pos_inc  = NCH_W'(ent_ch) + NCH_W'(1);
    pos_next = ((pos_inc >= n_eff) || buffer_end) ? '0 : pos_inc[POS_W-1:0];
  end

  // magnitude, unsigned formats kept doubled around the midpoint
  always_comb begin
    s8_neg  = 9'h100 - {1'b0, sample_bits[7:0]};
    s16_neg = 17'h10000 - {1'b0, sample_bits[15:0]};
    case (sample_format)
      FMT_U8:  uval = {24'b0, sample_bits[7:0]};
      FMT_U16: uval = {16'b0, sample_bits[15:0]};
      default: uval = sample_bits;
    endcase
    dbl    = {uval, 1'b0};
    fs_ext = {1'b0, fs};
    udiff  = (dbl >= fs_ext) ? (dbl - fs_ext) : (fs_ext - dbl);
    case (sample_format)
      FMT_S8:  ent_mag = sample_bits[7] ? {23'b0, s8_neg} : {24'b0, sample_bits[7:0]};
      FMT_S16: ent_mag = sample_bits[15] ? {15'b0, s16_neg} : {16'b0, sample_bits[15:0]};
      FMT_S32: ent_mag = sample_bits[31] ? (32'd0 - sample_bits) : sample_bits;
      FMT_U8, FMT_U16, FMT_U32: ent_mag = udiff[PEAK_W-1:0];
      default: ent_mag = '0;
    endcase
  end

  assign ent_last = buffer_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

endmodule

// File: rtl/apm_back.sv
// back end: peak store and level report sequencer with serial divider
module apm_back import apm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int POS_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int NCH_W        = $clog2(MAX_CHANNELS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [FMT_W-1:0]   sample_format,
  input  logic [NCH_W-1:0]   n_eff,
  input  logic               q_empty,
  input  logic [POS_W-1:0]   q_ch,
  input  logic [PEAK_W-1:0]  q_mag,
  input  logic               q_last,
  output logic               q_pop,
  input  logic               res_full,
  output logic               res_push,
  output apm_result_t        res
);

  typedef enum logic [1:0] {
    RUN,
    LOAD,
    DIV,
    SEND
  } state_t;

  state_t                state;
  logic [PEAK_W-1:0]     peak [MAX_CHANNELS];
  logic [POS_W-1:0]      idx;
  logic [PROD_W-1:0]     rem;
  logic [PROD_W-2:0]     dvs;
  logic [QUOT_W-1:0]     quot;
  logic [2:0]            step;
  logic [LEVEL_W-1:0]    level;
  logic [POS_W-1:0]      rd_addr;
  logic [PEAK_W-1:0]     rd_peak;
  logic [PEAK_W-1:0]     fs;
  logic [PROD_W-1:0]     prod;
  logic                  ge;
  logic                  is_last;
  logic [POS_W+2:0]      idx_ext;

  assign fs      = full_scale(sample_format);
  assign rd_addr = (state == RUN) ? q_ch : idx;
  assign rd_peak = peak[rd_addr];
  assign prod    = (PROD_W'(rd_peak) << 6) + (PROD_W'(rd_peak) << 5) + (PROD_W'(rd_peak) << 2);
  assign ge      = (rem >= {1'b0, dvs});
  assign is_last = ((NCH_W'(idx) + NCH_W'(1)) == n_eff);
  assign idx_ext = {3'b0, idx};

  assign q_pop    = (state == RUN) && !q_empty;
  assign res_push = (state == SEND) && !res_full;

  always_comb begin
    res.channel_number = idx_ext[CHAN_NUM_W-1:0];
    res.level_percent  = level;
    res.last_level     = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RUN;
      idx   <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peak[i] <= '0;
      end
    end else begin
      case (state)
        RUN: begin
          if (q_pop) begin
            if (q_mag > rd_peak) begin
              peak[q_ch] <= q_mag;
            end
            if (q_last) begin
              idx   <= '0;
              state <= LOAD;
            end
          end
        end
        LOAD: begin
          rem  <= prod;
          dvs  <= {fs, 6'b0};
          quot <= '0;
          step <= 3'd6;
          if (fs == '0) begin
            level <= '0;
            state <= SEND;
          end else if (rd_peak >= fs) begin
            level <= LEVEL_MAX;
            state <= SEND;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (ge) begin
            rem <= rem - {1'b0, dvs};
          end
          quot <= {quot[QUOT_W-2:0], ge};
          dvs  <= dvs >> 1;
          if (step == '0) begin
            level <= {quot[QUOT_W-2:0], ge};
            state <= SEND;
          end else begin
            step <= step - 1'b1;
          end
        end
        SEND: begin
          if (res_push) begin
            if (is_last) begin
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                peak[i] <= '0;
              end
              state <= RUN;
            end else begin
              idx   <= idx + 1'b1;
              state <= LOAD;
            end
          end
        end
        default: begin
          state <= RUN;
        end
      endcase
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res.level_percent <= LEVEL_MAX))
    else $error("level above full scale");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_level) |=> (state == RUN))
    else $error("report did not finish after final channel");

  a_next_channel: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res.last_level) |=> (state == LOAD && idx == $past(idx) + 1'b1))
    else $error("report skipped a channel");

  a_peaks_cleared: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_level) |=> (peak[0] == '0))
    else $error("peaks not cleared at buffer end");

endmodule

// File: rtl/audio_peak_level_meter.sv
// Per-channel PCM peak level meter: samples are taken into a two-entry queue at one per
// cycle while the peak store keeps up; each queued sample updates its channel's peak
// when it is popped. A sample marked as buffer end starts the level report, which for
// each active channel takes one load, seven restoring divide steps by the format's full
// scale (skipped when the scale is zero or the peak reaches it) and one transfer into the
// four-entry result queue, so the input stalls during the report once the sample queue
// is full. There is no clearing pass after reset.
module audio_peak_level_meter import apm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_W-1:0]    sample_bits,
  input  logic                   buffer_end,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAN_NUM_W-1:0]  channel_number,
  output logic [LEVEL_W-1:0]     level_percent,
  output logic                   last_level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
  localparam int ENT_W = 1 + POS_W + PEAK_W;

  logic [FMT_W-1:0]   sample_format;
  logic [COUNT_W-1:0] channel_count;
  logic [NCH_W-1:0]   n_eff;
  logic               take;
  logic [POS_W-1:0]   f_ch;
  logic [PEAK_W-1:0]  f_mag;
  logic               f_last;
  logic [ENT_W-1:0]   q_wdata;
  logic [ENT_W-1:0]   q_rdata;
  logic               q_empty;
  logic               q_pop;
  logic               res_full;
  logic               res_push;
  apm_result_t        res_in;
  apm_result_t        res_out;
  logic [RESULT_W-1:0] res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_RESET;
      channel_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_FORMAT: sample_format <= cfg_data[FMT_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective channel count: zero reads as one, clamped to the channel limit
  always_comb begin
    if (channel_count == '0) begin
      n_eff = NCH_W'(1);
    end else if ({1'b0, channel_count} > (COUNT_W + 1)'(MAX_CHANNELS)) begin
      n_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      n_eff = NCH_W'(channel_count);
    end
  end

  assign take    = push && !full;
  assign q_wdata = {f_last, f_ch, f_mag};

  apm_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .sample_format (sample_format),
    .n_eff         (n_eff),
    .sample_bits   (sample_bits),
    .buffer_end    (buffer_end),
    .ent_ch        (f_ch),
    .ent_mag       (f_mag),
    .ent_last      (f_last)
  );

  apm_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  apm_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .n_eff         (n_eff),
    .q_empty       (q_empty),
    .q_ch          (q_rdata[PEAK_W +: POS_W]),
    .q_mag         (q_rdata[PEAK_W-1:0]),
    .q_last        (q_rdata[ENT_W-1]),
    .q_pop         (q_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  apm_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out        = apm_result_t'(res_rdata);
  assign channel_number = res_out.channel_number;
  assign level_percent  = res_out.level_percent;
  assign last_level     = res_out.last_level;

endmodule

// File: bench/audio_peak_level_meter_checker.sv
`timescale 1ns / 100ps
// checker for the audio peak level meter: tracks peaks, predicts levels and compares them
module audio_peak_level_meter_checker import apm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   full,
  input  logic [SAMPLE_W-1:0]    sample_bits,
  input  logic                   buffer_end,
  input  logic                   empty,
  input  logic                   pop,
  input  logic [CHAN_NUM_W-1:0]  channel_number,
  input  logic [LEVEL_W-1:0]     level_percent,
  input  logic                   last_level,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     levels_pending,
  output int                     levels_checked
);

  logic [FMT_W-1:0]   fmt_q;
  logic [COUNT_W-1:0] count_q;
  logic [PEAK_W-1:0]  peak_q [MAX_CHANNELS];
  int unsigned        position_q;
  apm_result_t        expected_levels [$];
  int                 errors;
  int                 checked;

  function automatic logic [63:0] scale_of(input logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_S8:  return 64'd127;
      FMT_S16: return 64'd32767;
      FMT_S32: return 64'd2147483647;
      FMT_U8:  return 64'd255;
      FMT_U16: return 64'd65535;
      FMT_U32: return 64'd4294967295;
      default: return 64'd0;
    endcase
  endfunction

  // signed: absolute value; unsigned: doubled distance from the midpoint
  function automatic logic [PEAK_W-1:0] magnitude_of(input logic [FMT_W-1:0] fmt,
                                                     input logic [SAMPLE_W-1:0] raw);
    logic [32:0] d;
    logic [32:0] fs;
    logic [31:0] v;
    case (fmt)
      FMT_S8:  return raw[7] ? 32'(9'h100 - {1'b0, raw[7:0]}) : {24'd0, raw[7:0]};
      FMT_S16: return raw[15] ? 32'(17'h10000 - {1'b0, raw[15:0]}) : {16'd0, raw[15:0]};
      FMT_S32: return raw[31] ? (~raw + 32'd1) : raw;
      FMT_U8, FMT_U16, FMT_U32: begin
        if (fmt == FMT_U8) v = {24'd0, raw[7:0]};
        else if (fmt == FMT_U16) v = {16'd0, raw[15:0]};
        else v = raw;
        fs = 33'(scale_of(fmt));
        d = {v, 1'b0};
        return (d >= fs) ? 32'(d - fs) : 32'(fs - d);
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] level_of(input logic [PEAK_W-1:0] peak,
                                                  input logic [FMT_W-1:0] fmt);
    logic [63:0] fs;
    logic [63:0] q;
    fs = scale_of(fmt);
    if (fs == 64'd0) return '0;
    q = ({32'd0, peak} * 64'd100) / fs;
    if (q > 64'(LEVEL_MAX)) q = 64'(LEVEL_MAX);
    return q[LEVEL_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    int unsigned n;
    int unsigned pos;
    logic [PEAK_W-1:0] mag;
    apm_result_t want;
    apm_result_t got;
    if (rst) begin
      fmt_q = FMT_RESET;
      count_q = COUNT_RESET;
      for (int i = 0; i < MAX_CHANNELS; i++) peak_q[i] = '0;
      position_q = 0;
      expected_levels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_FORMAT: fmt_q = cfg_data[FMT_W-1:0];
          REG_CHANNEL_COUNT: count_q = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        got.channel_number = channel_number;
        got.level_percent = level_percent;
        got.last_level = last_level;
        checked++;
        if (expected_levels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: level transfer with nothing expected: ch %0d level %0d last %0b",
                     $realtime, got.channel_number, got.level_percent, got.last_level);
        end else begin
          want = expected_levels.pop_front();
          if (got.channel_number !== want.channel_number ||
              got.level_percent !== want.level_percent ||
              got.last_level !== want.last_level) begin
            errors++;
            if (errors <= 10)
              $display("%0t: level mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $realtime, want.channel_number, want.level_percent, want.last_level,
                       got.channel_number, got.level_percent, got.last_level);
          end
        end
      end
      if (push && !full) begin
        n = (count_q == 0) ? 1 : (count_q > MAX_CHANNELS) ? MAX_CHANNELS : count_q;
        pos = (position_q >= n) ? 0 : position_q;
        mag = magnitude_of(fmt_q, sample_bits);
        if (mag > peak_q[pos]) peak_q[pos] = mag;
        pos++;
        position_q = (pos >= n) ? 0 : pos;
        if (buffer_end) begin
          for (int i = 0; i < n; i++) begin
            want.channel_number = CHAN_NUM_W'(i);
            want.level_percent = level_of(peak_q[i], fmt_q);
            want.last_level = (i == n - 1);
            expected_levels.push_back(want);
          end
          for (int i = 0; i < MAX_CHANNELS; i++) peak_q[i] = '0;
          position_q = 0;
        end
      end
    end
    mismatch_count <= errors;
    levels_pending <= expected_levels.size();
    levels_checked <= checked;
  end

endmodule

// File: bench/audio_peak_level_meter_tb.sv
`timescale 1ns / 100ps
// testbench top for the audio peak level meter: stimulus, flow control and verdict
module audio_peak_level_meter_tb;
  import apm_pkg::*;

  localparam int ITEM_GOAL     = 360;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [SAMPLE_W-1:0]    sample_bits = '0;
  logic                   buffer_end = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [CHAN_NUM_W-1:0]  channel_number;
  logic [LEVEL_W-1:0]     level_percent;
  logic                   last_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatch_count;
  int levels_pending;
  int levels_checked;

  int                 samples_sent = 0;
  int                 buffers_sent = 0;
  int                 reg_writes = 0;
  bit                 steady = 1'b0;
  bit                 hold_request = 1'b0;
  logic [FMT_W-1:0]   cur_fmt = FMT_RESET;
  logic [COUNT_W-1:0] cur_count = COUNT_RESET;

  audio_peak_level_meter dut (.*);

  audio_peak_level_meter_checker chk (.*);

  always #5 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [FMT_W-1:0] fmt);
    int unsigned w;
    logic [63:0] span;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] mask;
    case (fmt)
      FMT_S8, FMT_U8:   w = 8;
      FMT_S16, FMT_U16: w = 16;
      default:          w = 32;
    endcase
    span = 64'd1 << w;
    mask = 32'(span - 64'd1);
    case ($urandom_range(0, 6))
      0: v = '0;
      1: v = mask;
      2: v = 32'(span >> 1);
      3: v = 32'((span >> 1) - 64'd1);
      4: v = 32'((span >> 1) + 64'd1);
      default: v = $urandom;
    endcase
    // junk above the sample width must be ignored
    if ($urandom_range(0, 1)) v = (v & mask) | ($urandom & ~mask);
    return v;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    sample_bits <= raw;
    buffer_end <= last;
    do @(posedge clk); while (full);
    samples_sent++;
    if (last) buffers_sent++;
  endtask

  task automatic send_buffer(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(cur_fmt), i == len - 1);
  endtask

  // stop sending and wait until every level has come out and the block is quiet
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (levels_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SAMPLE_FORMAT) cur_fmt = data[FMT_W-1:0];
    else cur_count = data[COUNT_W-1:0];
    reg_writes++;
  endtask

  initial begin
    do @(posedge clk); while (rst);
    forever begin : drain
      int stall;
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    int phase;
    int nbuf;
    int len;
    int n;
    int burst;
    logic [CFG_DATA_W-1:0] fmt_data;
    logic [CFG_DATA_W-1:0] count_data;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // signed 8: most negative saturates, upper junk ignored
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_S8));
    write_reg(REG_CHANNEL_COUNT, 4'd2);
    send_sample(32'h0000_0080, 1'b0);
    send_sample(32'h0000_007F, 1'b1);
    send_sample(32'hFFFF_FF81, 1'b0);
    send_sample(32'h0000_0001, 1'b1);

    // unsigned 8: ends of the range and just above the midpoint
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_U8));
    write_reg(REG_CHANNEL_COUNT, 4'd1);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_FF80, 1'b1);
    send_sample(32'h0000_00FF, 1'b1);

    // unsigned 16 with a partial frame
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_U16));
    write_reg(REG_CHANNEL_COUNT, 4'd3);
    send_sample(32'h0000_8000, 1'b0);
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h0000_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b1);

    // signed 32 over eight channels
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_S32));
    write_reg(REG_CHANNEL_COUNT, 4'd8);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);

    // unsigned 32, channel count above the maximum
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_U32));
    write_reg(REG_CHANNEL_COUNT, 4'd15);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);

    // channel count lowered mid-buffer
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_S16));
    write_reg(REG_CHANNEL_COUNT, 4'd4);
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h0000_8000, 1'b0);
    send_sample(32'h0000_1000, 1'b0);
    write_reg(REG_CHANNEL_COUNT, 4'd2);
    send_sample(32'h0000_0001, 1'b1);

    // format changed mid-buffer
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_S8));
    write_reg(REG_CHANNEL_COUNT, 4'd1);
    send_sample(32'h0000_007F, 1'b0);
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_U16));
    send_sample(32'h0000_8000, 1'b1);

    // unused format codes, zero channel count
    write_reg(REG_SAMPLE_FORMAT, 4'd6);
    write_reg(REG_CHANNEL_COUNT, 4'd0);
    send_sample(32'h0000_1234, 1'b1);
    write_reg(REG_SAMPLE_FORMAT, 4'hF);
    send_sample(32'hFFFF_FFFF, 1'b1);

    phase = 0;
    while (samples_sent < ITEM_GOAL) begin
      fmt_data = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(6, 15))
                                             : CFG_DATA_W'($urandom_range(0, 5));
      count_data = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom)
                                               : CFG_DATA_W'($urandom_range(1, 8));
      if (phase == 1) count_data = 4'd8;
      write_reg(REG_SAMPLE_FORMAT, fmt_data);
      write_reg(REG_CHANNEL_COUNT, count_data);
      n = (cur_count == 0) ? 1 : (cur_count > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : cur_count;
      steady = ($urandom_range(0, 3) == 0);
      nbuf = $urandom_range(2, 5);
      // long receiver hold while short eight-channel buffers keep coming
      if (phase == 1) begin
        steady = 1'b1;
        hold_request = 1'b1;
        nbuf = 6;
      end
      for (int b = 0; b < nbuf; b++) begin
        if (phase == 3 && b == 2) wait_drained();
        if (phase == 1) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 2 * n + 2);
        else len = n * $urandom_range(1, 3);
        send_buffer(len);
      end
      // leave a buffer open across the next register writes
      if ($urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, n);
        for (int i = 0; i < burst; i++) send_sample(pick_sample(cur_fmt), 1'b0);
      end
      phase++;
    end

    wait_drained();
    $display("covered %0d samples in %0d buffers over %0d register writes, %0d levels checked",
             samples_sent, buffers_sent, reg_writes, levels_checked);
    if (mismatch_count == 0 && levels_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d levels outstanding", levels_pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
